[hw/rtl/tgr_pkg.sv]
// Shared types, constants and the 5x7 font table of the text glyph rasterizer.
package tgr_pkg;

	localparam int COORD_WIDTH_DEF = 12;  // default internal coordinate width
	localparam int PIX_WIDTH       = 12;  // width of coordinate fields on the ports
	localparam int SIZE_WIDTH      = 11;  // width of rect_w and of dot offsets
	localparam int SCALE_WIDTH     = 8;
	localparam int COLOR_WIDTH     = 16;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam int GLYPH_COLS   = 5;
	localparam int GLYPH_ROWS   = 7;
	localparam int GLYPH_BITS   = GLYPH_COLS * GLYPH_ROWS;
	localparam int FONT_ENTRIES = 70;
	localparam int FONT_IDX_W   = $clog2(FONT_ENTRIES);

	// Character codes the decoder knows by name.
	localparam logic [7:0] CHAR_DASH  = 8'h2d;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
	localparam logic [7:0] CHAR_DIG_0 = 8'h30;
	localparam logic [7:0] CHAR_DIG_9 = 8'h39;
	localparam logic [7:0] CHAR_LT    = 8'h3c;
	localparam logic [7:0] CHAR_GT    = 8'h3e;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_DOT   = 8'h2e;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_COMMA = 8'h2c;
	localparam logic [7:0] CHAR_UNDER = 8'h5f;
	localparam logic [7:0] CHAR_CARET = 8'h5e;

	// Font table rows where the lowercase letters, the digits and each symbol start.
	localparam logic [FONT_IDX_W-1:0] IDX_LO_A  = FONT_IDX_W'(26);
	localparam logic [FONT_IDX_W-1:0] IDX_DIG_0 = FONT_IDX_W'(52);
	localparam logic [FONT_IDX_W-1:0] IDX_LT    = FONT_IDX_W'(62);
	localparam logic [FONT_IDX_W-1:0] IDX_GT    = FONT_IDX_W'(63);
	localparam logic [FONT_IDX_W-1:0] IDX_SLASH = FONT_IDX_W'(64);
	localparam logic [FONT_IDX_W-1:0] IDX_DOT   = FONT_IDX_W'(65);
	localparam logic [FONT_IDX_W-1:0] IDX_COLON = FONT_IDX_W'(66);
	localparam logic [FONT_IDX_W-1:0] IDX_COMMA = FONT_IDX_W'(67);
	localparam logic [FONT_IDX_W-1:0] IDX_UNDER = FONT_IDX_W'(68);
	localparam logic [FONT_IDX_W-1:0] IDX_CARET = FONT_IDX_W'(69);

	// Dot multiples of the dash bar row and the cursor advance.
	localparam int DASH_ROW     = 3;
	localparam int ADVANCE_DOTS = 6;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_CHAR_SCALE = 2'd0,
		REG_TEXT_COLOR = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DASH,
		ST_ADV
	} state_t;

	typedef struct packed {
		logic [7:0]           char_code;
		logic                 new_string;
		logic [PIX_WIDTH-1:0] start_x;
		logic [PIX_WIDTH-1:0] start_y;
	} in_word_t;

	typedef struct packed {
		logic [PIX_WIDTH-1:0]   rect_x;
		logic [PIX_WIDTH-1:0]   rect_y;
		logic [SIZE_WIDTH-1:0]  rect_w;
		logic [SCALE_WIDTH-1:0] rect_h;
		logic [COLOR_WIDTH-1:0] rect_color;
		logic                   last_rect;
	} out_word_t;

	typedef struct packed {
		logic                  known;
		logic [FONT_IDX_W-1:0] idx;
	} font_ref_t;

	// One byte per column, column 0 first; bit n of a byte is row n.
	typedef logic [0:GLYPH_COLS-1][7:0] glyph_cols_t;

	localparam glyph_cols_t FONT_ROM [FONT_ENTRIES] = '{
		40'h7e1111117e, 40'h7f49494936, 40'h3e41414122, 40'h7f4141221c,
		40'h7f49494941, 40'h7f09090901, 40'h3e4149497a, 40'h7f0808087f,
		40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
		40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906,
		40'h3e4151215e, 40'h7f09192946, 40'h4649494931, 40'h01017f0101,
		40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
		40'h0708700807, 40'h6151494543,
		40'h2054545478, 40'h7f48484830, 40'h3844444428, 40'h304848497f,
		40'h3854545458, 40'h087e090102, 40'h18a4a4a870, 40'h7f10081060,
		40'h00447d4000, 40'h4080847d00, 40'h7f10284400, 40'h00417f4000,
		40'h7c04780478, 40'h7c08040478, 40'h3844444438, 40'hfc24242418,
		40'h18242424fc, 40'h7c08040408, 40'h4854545424, 40'h043e444424,
		40'h3c4040407c, 40'h1c2040201c, 40'h3c4038403c, 40'h4428102844,
		40'h1ca0a0a07c, 40'h4464544c44,
		40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e,
		40'h0008142241, 40'h4122140800, 40'h1008040201, 40'h0000400000,
		40'h0000440000, 40'h0040300000, 40'h4040404040, 40'h0402010204
	};

	// Map a character code to its font row; known is low when there is no glyph.
	function automatic font_ref_t font_lookup(input logic [7:0] code);
		font_ref_t r;
		r.known = 1'b1;
		r.idx   = '0;
		if (code >= CHAR_UP_A && code <= CHAR_UP_Z) begin
			r.idx = FONT_IDX_W'(code - CHAR_UP_A);
		end else if (code >= CHAR_LO_A && code <= CHAR_LO_Z) begin
			r.idx = IDX_LO_A + FONT_IDX_W'(code - CHAR_LO_A);
		end else if (code >= CHAR_DIG_0 && code <= CHAR_DIG_9) begin
			r.idx = IDX_DIG_0 + FONT_IDX_W'(code - CHAR_DIG_0);
		end else begin
			unique case (code)
				CHAR_LT:    r.idx = IDX_LT;
				CHAR_GT:    r.idx = IDX_GT;
				CHAR_SLASH: r.idx = IDX_SLASH;
				CHAR_DOT:   r.idx = IDX_DOT;
				CHAR_COLON: r.idx = IDX_COLON;
				CHAR_COMMA: r.idx = IDX_COMMA;
				CHAR_UNDER: r.idx = IDX_UNDER;
				CHAR_CARET: r.idx = IDX_CARET;
				default:    r.known = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage

[hw/rtl/tgr_font_rom.sv]
// Font ROM with a registered read port; returns the 35 glyph dots of a character.
module tgr_font_rom (
	input  logic                              clk,
	input  logic                              rd_en,
	input  logic [7:0]                        code,
	output logic [tgr_pkg::GLYPH_BITS-1:0]    glyph
);

	tgr_pkg::font_ref_t          ref_w;
	tgr_pkg::glyph_cols_t        cols_w;
	logic [tgr_pkg::GLYPH_BITS-1:0] packed_w;
	logic [tgr_pkg::GLYPH_BITS-1:0] glyph_q;

	assign ref_w  = tgr_pkg::font_lookup(code);
	assign cols_w = tgr_pkg::FONT_ROM[ref_w.idx];

	// Drop bit 7 of every column; dot (col,row) lands at col*7+row.
	always_comb begin
		for (int c = 0; c < tgr_pkg::GLYPH_COLS; c++) begin
			for (int r = 0; r < tgr_pkg::GLYPH_ROWS; r++) begin
				packed_w[c * tgr_pkg::GLYPH_ROWS + r] = cols_w[c][r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			glyph_q <= packed_w;
		end
	end

	assign glyph = glyph_q;

endmodule

[hw/rtl/text_glyph_rect_rasterizer_top.sv]
// Top level of the text glyph rasterizer: character words in, rectangle words out.
//
//  channel  | handshake           | word                 | direction
//  ---------+---------------------+----------------------+----------
//  in       | in_valid / in_stall | tgr_pkg::in_word_t   | input
//  out      | out_valid/out_stall | tgr_pkg::out_word_t  | output
//  cfg      | cfg_we              | cfg_index, cfg_data  | input
//
// A glyph character is accepted in idle, where the font ROM is read; then the
// single-dot scan sequencer steps through its 35 dots in turn. A dash uses the
// dash state, an unknown code or space the advance state, and a zero scale
// stays in idle. A lit dot or the dash bar waits while the output is stalled; the
// output register lets the last rectangle wait while the next word is accepted.
// Reset: scale 1, color 0xFFFF, cursor and line at 0, no word pending.
module text_glyph_rect_rasterizer_top #(
	parameter int COORD_WIDTH = tgr_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  tgr_pkg::in_word_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output tgr_pkg::out_word_t                   out_data,
	input  logic                                 cfg_we,
	input  logic [tgr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [tgr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	localparam int CW    = COORD_WIDTH;
	localparam int OW    = tgr_pkg::SIZE_WIDTH;
	localparam int PW    = tgr_pkg::PIX_WIDTH;
	localparam int SW    = ((CW > OW) ? CW : OW) + 1;
	localparam int GB    = tgr_pkg::GLYPH_BITS;
	localparam int KW    = $clog2(GB);
	localparam int RW    = $clog2(tgr_pkg::GLYPH_ROWS);
	localparam logic [CW-1:0]  COORD_MAX = '1;
	localparam logic [KW-1:0]  K_LAST    = KW'(GB - 1);
	localparam logic [RW-1:0]  ROW_LAST  = RW'(tgr_pkg::GLYPH_ROWS - 1);

	// Saturating add of a coordinate and a dot offset.
	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
	                                          input logic [OW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s > SW'(COORD_MAX)) begin
			return COORD_MAX;
		end
		return s[CW-1:0];
	endfunction

	// Configuration registers.
	logic [tgr_pkg::SCALE_WIDTH-1:0] scale_q;
	logic [tgr_pkg::COLOR_WIDTH-1:0] color_q;

	// Sequencer state and per-character working registers.
	tgr_pkg::state_t                 state_q, state_d;
	logic [CW-1:0]                   cursor_x_q, line_y_q;
	logic [tgr_pkg::SCALE_WIDTH-1:0] s_q;
	logic [KW-1:0]                   k_q;
	logic [RW-1:0]                   row_q;
	logic [OW-1:0]                   col_off_q, row_off_q;
	logic [GB-1:0]                   done_q;

	tgr_pkg::out_word_t out_q;
	logic               out_valid_q;

	logic [GB-1:0] glyph;
	logic          accept, can_load;
	logic          scan_step, dash_emit, adv_step, scan_end;
	logic          cur_lit, last_lit;
	logic [GB-1:0] through;
	tgr_pkg::font_ref_t in_ref;
	logic [OW-1:0] s_w, three_s, five_s, six_s;
	logic [CW-1:0] base_x, base_y, adv_x, dot_x, dot_y, dash_y;

	assign accept   = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;
	assign in_ref   = tgr_pkg::font_lookup(in_data.char_code);

	tgr_font_rom u_rom (
		.clk   (clk),
		.rd_en (accept),
		.code  (in_data.char_code),
		.glyph (glyph)
	);

	// Dot multiples by shift and add.
	assign s_w     = OW'(s_q);
	assign three_s = (s_w << 1) + s_w;
	assign five_s  = (s_w << 2) + s_w;
	assign six_s   = (s_w << 2) + (s_w << 1);

	assign base_x = cursor_x_q;
	assign base_y = line_y_q;
	assign adv_x  = sat_add(base_x, six_s);
	assign dot_x  = sat_add(base_x, col_off_q);
	assign dot_y  = sat_add(base_y, row_off_q);
	assign dash_y = sat_add(base_y, three_s);

	// The current dot, and whether any lit dot lies past it.
	assign through  = {done_q[GB-2:0], 1'b1};
	assign cur_lit  = glyph[k_q];
	assign last_lit = ~|(glyph & ~through);
	assign scan_end = (k_q == K_LAST);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tgr_pkg::ST_IDLE: begin
				if (accept) begin
					if (scale_q == '0) begin
						state_d = tgr_pkg::ST_IDLE;
					end else if (in_data.char_code == tgr_pkg::CHAR_DASH) begin
						state_d = tgr_pkg::ST_DASH;
					end else if (in_ref.known) begin
						state_d = tgr_pkg::ST_SCAN;
					end else begin
						state_d = tgr_pkg::ST_ADV;
					end
				end
			end
			tgr_pkg::ST_SCAN: begin
				if (scan_step && scan_end) begin
					state_d = tgr_pkg::ST_IDLE;
				end
			end
			tgr_pkg::ST_DASH: begin
				if (can_load) begin
					state_d = tgr_pkg::ST_IDLE;
				end
			end
			tgr_pkg::ST_ADV: state_d = tgr_pkg::ST_IDLE;
			default:         state_d = tgr_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_stall  = 1'b1;
		scan_step = 1'b0;
		dash_emit = 1'b0;
		adv_step  = 1'b0;
		unique case (state_q)
			tgr_pkg::ST_IDLE: in_stall  = 1'b0;
			// Unlit dots pass freely; a lit dot waits for the output register.
			tgr_pkg::ST_SCAN: scan_step = !cur_lit || can_load;
			tgr_pkg::ST_DASH: dash_emit = can_load;
			tgr_pkg::ST_ADV:  adv_step  = 1'b1;
			default:          in_stall  = 1'b1;
		endcase
	end

	// Configuration writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= tgr_pkg::SCALE_WIDTH'(1);
			color_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tgr_pkg::REG_CHAR_SCALE: scale_q <= cfg_data[tgr_pkg::SCALE_WIDTH-1:0];
				tgr_pkg::REG_TEXT_COLOR: color_q <= cfg_data[tgr_pkg::COLOR_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Control state: sequencer, cursor, dot counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tgr_pkg::ST_IDLE;
			cursor_x_q <= '0;
			line_y_q   <= '0;
			k_q        <= '0;
			row_q      <= '0;
			done_q     <= '0;
			s_q        <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				// Load the cursor of a new string, then rewind the dot scan.
				if (in_data.new_string) begin
					cursor_x_q <= CW'(in_data.start_x);
					line_y_q   <= CW'(in_data.start_y);
				end
				s_q    <= scale_q;
				k_q    <= '0;
				row_q  <= '0;
				done_q <= '0;
			end
			if (scan_step) begin
				k_q    <= k_q + KW'(1);
				done_q <= through;
				if (row_q == ROW_LAST) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end
			// Advance the cursor once the character is finished.
			if ((scan_step && scan_end) || dash_emit || adv_step) begin
				cursor_x_q <= adv_x;
			end
		end
	end

	// Dot offsets follow the row and column counters.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_off_q <= '0;
			row_off_q <= '0;
		end else if (scan_step) begin
			if (row_q == ROW_LAST) begin
				row_off_q <= '0;
				col_off_q <= col_off_q + s_w;
			end else begin
				row_off_q <= row_off_q + s_w;
			end
		end
	end

	// Output register: hold while stalled, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((scan_step && cur_lit) || dash_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_step && cur_lit) begin
			out_q.rect_x     <= PW'(dot_x);
			out_q.rect_y     <= PW'(dot_y);
			out_q.rect_w     <= s_w;
			out_q.rect_h     <= s_q;
			out_q.rect_color <= color_q;
			out_q.last_rect  <= last_lit;
		end else if (dash_emit) begin
			out_q.rect_x     <= PW'(base_x);
			out_q.rect_y     <= PW'(dash_y);
			out_q.rect_w     <= five_s;
			out_q.rect_h     <= s_q;
			out_q.rect_color <= color_q;
			out_q.last_rect  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// A busy sequencer always works with a nonzero scale.
	a_busy_scale: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != tgr_pkg::ST_IDLE |-> s_q != '0)
		else $error("busy with zero scale");

	// Every rectangle shown has a nonzero size.
	a_rect_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.rect_w != '0 && out_q.rect_h != '0))
		else $error("empty rectangle emitted");

	// The dot index never runs past the glyph during a scan.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tgr_pkg::ST_SCAN |-> k_q <= K_LAST)
		else $error("scan index past glyph");

	// The cursor holds until the scan finishes.
	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tgr_pkg::ST_SCAN && !(scan_step && scan_end))
		|=> $stable(cursor_x_q))
		else $error("cursor moved mid-scan");

	// The scan's final step leaves no lit dot without a last mark.
	a_scan_last: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_step && cur_lit && scan_end) |-> last_lit)
		else $error("final dot not marked last");
`endif

endmodule
